/* hdl/adcb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adcb_pkg
// Shared types and constants for the adaptive decimation buffer.
// ----------------------------------------------------------------------------
package adcb_pkg;
  localparam int DEPTH      = 1024;
  localparam int LANES      = 4;
  localparam int VALUE_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = ADDR_BITS + 1;
  localparam int MIN_LIMIT  = 16;
  localparam int MAX_EXP    = 31;
  localparam int REACH_BITS = VALUE_BITS + 1;
  localparam int VEC_BITS   = LANES * VALUE_BITS;
  localparam int WORD       = TIME_BITS + VEC_BITS;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [REACH_BITS-1:0] reach_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_CFETCH= 6'b000100,
    ST_CWAIT = 6'b001000,
    ST_CPICK = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;
endpackage
`default_nettype wire

/* hdl/adcb_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adcb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/adcb_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adcb_lane
// One lane: absolute differences of two candidates against the kept entry.
// ----------------------------------------------------------------------------
module adcb_lane
  import adcb_pkg::*;
(
  input  wire value_t a,
  input  wire value_t b,
  input  wire value_t ref_v,
  output reach_t      diff_a,
  output reach_t      diff_b
);
  logic signed [REACH_BITS-1:0] da, db;

  always_comb begin
    da = REACH_BITS'(a) - REACH_BITS'(ref_v);
    db = REACH_BITS'(b) - REACH_BITS'(ref_v);
    diff_a = da[REACH_BITS-1] ? reach_t'(-da) : reach_t'(da);
    diff_b = db[REACH_BITS-1] ? reach_t'(-db) : reach_t'(db);
  end
endmodule
`default_nettype wire

/* hdl/adcb_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adcb_merge
// Runs the lanes and merges their differences into a pick decision.
// ----------------------------------------------------------------------------
module adcb_merge
  import adcb_pkg::*;
(
  input  wire logic [VEC_BITS-1:0] vec_a,
  input  wire logic [VEC_BITS-1:0] vec_b,
  input  wire logic [VEC_BITS-1:0] vec_ref,
  output logic                     pick_b
);
  reach_t da [LANES];
  reach_t db [LANES];
  reach_t ma, mb;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    adcb_lane u_lane (
      .a     (value_t'(vec_a[l*VALUE_BITS +: VALUE_BITS])),
      .b     (value_t'(vec_b[l*VALUE_BITS +: VALUE_BITS])),
      .ref_v (value_t'(vec_ref[l*VALUE_BITS +: VALUE_BITS])),
      .diff_a(da[l]),
      .diff_b(db[l])
    );
  end

  // Largest difference over lanes; a small fixed-depth reduction.
  always_comb begin
    ma = '0;
    mb = '0;
    for (int l = 0; l < LANES; l++) begin
      if (da[l] > ma) ma = da[l];
      if (db[l] > mb) mb = db[l];
    end
    pick_b = mb > ma;
  end
endmodule
`default_nettype wire

/* hdl/adaptive_decimation_capture_buffer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_decimation_capture_buffer
// Decimating capture store with in-place halving compaction and readback.
// ----------------------------------------------------------------------------
// An append result is registered in the output state after the item is accepted,
// a read result after a read state for the registered store read; either waits
// there until the previous result has drained. A waiting result only holds back
// the result of the next item, not its acceptance; a new item is accepted only
// once the last one is through. A store that reaches the limit is compacted
// first, one kept slot at a time: even read, odd read, wait, write.
// Reset (synchronous, rst high) clears count, counter, exponent, sets limit 1024.
module adaptive_decimation_capture_buffer
  import adcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: sample_limit[10:0].
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // tdata: sample_time[31:0], lane0..lane3 [95:32], read_index[105:96].
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [111:0] s_tdata,
  // tuser: func.
  input  wire logic        s_tuser,
  // tdata: was_stored[0], entry_count[11:1], decimation_log2[16:12],
  // read_valid[17], out_time[49:18], out_lane0..3 [113:50].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [119:0]     m_tdata
);
  state_t state;
  logic [CNT_BITS-1:0]  limit, count;
  logic [31:0]          arrivals;
  logic [4:0]           dexp;

  // Item latched on accept.
  logic                 it_func;
  logic [TIME_BITS-1:0] it_time;
  logic [VEC_BITS-1:0]  it_vec;
  logic [ADDR_BITS-1:0] it_idx;

  // Compaction walk.
  logic [ADDR_BITS-1:0] k;
  logic [CNT_BITS-1:0]  kept;
  logic [1:0]           phase;
  logic [TIME_BITS-1:0] a_time;
  logic [VEC_BITS-1:0]  a_vec, ref_vec;

  // RAM ports (time and lanes kept as one word).
  logic                 we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [WORD-1:0]      wdata, rdata;

  adcb_ram #(.WIDTH(WORD), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic pick_b;
  adcb_merge u_merge (
    .vec_a(a_vec), .vec_b(rdata[VEC_BITS-1:0]), .vec_ref(ref_vec), .pick_b(pick_b)
  );

  logic [CNT_BITS-1:0]  cfg_lim;
  logic                 take;
  logic [31:0]          fmask;
  logic [CNT_BITS-1:0]  b_idx;
  logic                 stored;
  logic                 out_free;
  logic                 out_rv;
  logic [CNT_BITS-1:0]  cnt_inc;
  logic [4:0]           dexp_up;
  logic [119:0]         out_word;
  logic [119:0]         cmp_word;

  // Packs one result item; entry holds the time stamp above the lane values.
  function automatic logic [119:0] pack_result(
    input logic                st,
    input logic [CNT_BITS-1:0] cnt,
    input logic [4:0]          ex,
    input logic                rv,
    input logic [WORD-1:0]     entry
  );
    return {6'd0, entry[VEC_BITS-1:0], entry[WORD-1:VEC_BITS], rv, ex, cnt, st};
  endfunction

  // A limit write is taken only between items, so it never meets one in flight.
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    cfg_lim = cfg_data[CNT_BITS-1:0];
    if (cfg_lim < CNT_BITS'(MIN_LIMIT)) cfg_lim = CNT_BITS'(MIN_LIMIT);
    if (cfg_lim > CNT_BITS'(DEPTH))     cfg_lim = CNT_BITS'(DEPTH);
    fmask = (32'd1 << dexp) - 32'd1;
    take  = (arrivals & fmask) == 32'd0;
    b_idx = {k, 1'b1};
    stored   = (it_func == FUNC_APPEND) && take && (count < CNT_BITS'(DEPTH));
    out_free = !m_tvalid || m_tready;
    out_rv   = (it_func == FUNC_READ) && ({1'b0, it_idx} < count);
    cnt_inc  = count + CNT_BITS'(1);
    dexp_up  = (dexp != 5'(MAX_EXP)) ? dexp + 5'd1 : dexp;
    out_word = pack_result(stored, stored ? cnt_inc : count, dexp, out_rv,
                           out_rv ? rdata : '0);
    cmp_word = pack_result(1'b1, kept, dexp_up, 1'b0, '0);
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_BITS-1:0];
    wdata = {it_time, it_vec};
    raddr = it_idx;
    case (state)
      ST_IDLE: begin
        raddr = s_tdata[105:96];
      end
      ST_CFETCH: begin
        raddr = phase[0] ? b_idx[ADDR_BITS-1:0] : ADDR_BITS'({k, 1'b0});
      end
      ST_CWAIT: begin
        // Keep the odd entry on the read port until the pick.
        raddr = b_idx[ADDR_BITS-1:0];
      end
      ST_OUT: begin
        // An append that is taken lands at the next free slot.
        we = stored && out_free;
      end
      ST_CPICK: begin
        we    = 1'b1;
        waddr = k;
        wdata = (k != '0 && b_idx < count && pick_b) ? rdata : {a_time, a_vec};
      end
      default: begin
        raddr = it_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      limit    <= CNT_BITS'(DEPTH);
      count    <= '0;
      arrivals <= '0;
      dexp     <= '0;
      m_tvalid <= 1'b0;
      phase    <= '0;
      k        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          if (cfg_valid) begin
            limit    <= cfg_lim;
            count    <= '0;
            arrivals <= '0;
            dexp     <= '0;
          end else if (s_tvalid && s_tready) begin
            it_func <= s_tuser;
            it_time <= s_tdata[31:0];
            it_vec  <= s_tdata[95:32];
            it_idx  <= s_tdata[105:96];
            state   <= (s_tuser == FUNC_READ) ? ST_READ : ST_OUT;
          end
        end
        ST_READ: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Once the previous result has drained, produce this one or, if the store
          // reaches the limit, start compaction; appends write the store here.
          if (out_free) begin
            if (it_func == FUNC_APPEND) arrivals <= arrivals + 32'd1;
            if (stored) count <= cnt_inc;
            if (stored && cnt_inc >= limit) begin
              kept     <= (cnt_inc + CNT_BITS'(1)) >> 1;
              k        <= '0;
              phase    <= '0;
              state    <= ST_CFETCH;
              m_tvalid <= 1'b0;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= out_word;
              state    <= ST_IDLE;
            end
          end
        end
        ST_CFETCH: begin
          // phase 0 issues the even read, phase 1 the odd read.
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else begin
            a_time <= rdata[WORD-1:VEC_BITS];
            a_vec  <= rdata[VEC_BITS-1:0];
            state  <= ST_CWAIT;
          end
        end
        ST_CWAIT: state <= ST_CPICK;
        ST_CPICK: begin
          ref_vec <= wdata[VEC_BITS-1:0];
          if (CNT_BITS'(k) + 1'b1 >= kept) begin
            count    <= kept;
            arrivals <= '0;
            dexp     <= dexp_up;
            m_tvalid <= 1'b1;
            m_tdata  <= cmp_word;
            state    <= ST_IDLE;
          end else begin
            k     <= k + 1'b1;
            phase <= '0;
            state <= ST_CFETCH;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_BITS'(DEPTH))
    else $error("count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CFETCH) |-> !m_tvalid) else $error("output during compaction");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CPICK) |=> (state == ST_CFETCH || state == ST_IDLE))
    else $error("bad compaction step");
endmodule
`default_nettype wire

/* dv/adcb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcb_checker
// Watches the config, input and output channels of the capture buffer, keeps
// its own copy of the store, predicts every result and compares field by field.
// ----------------------------------------------------------------------------
module adcb_checker
  import adcb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [119:0] m_tdata,
  output int                errors,
  output int                pending
);
  typedef struct packed {
    logic [15:0] l3, l2, l1, l0;
    logic [31:0] t;
    logic        rv;
    logic [4:0]  exp;
    logic [10:0] cnt;
    logic        stored;
  } result_t;

  logic [31:0]         times [DEPTH];
  logic [VEC_BITS-1:0] lanes [DEPTH];
  int unsigned         count, arrivals, expo, limit;
  result_t             expected_q[$];

  assign pending = expected_q.size();

  function automatic int reach(int a, int k);
    int best, d;
    best = 0;
    for (int l = 0; l < LANES; l++) begin
      d = int'(value_t'(lanes[a][l*16 +: 16])) - int'(value_t'(lanes[k][l*16 +: 16]));
      if (d < 0) d = -d;
      if (d > best) best = d;
    end
    return best;
  endfunction

  task automatic halve();
    int unsigned kept, a, pick;
    kept = (count + 1) / 2;
    for (int k = 0; k < kept; k++) begin
      a = 2 * k;
      pick = a;
      if (a + 1 < count && k > 0 && reach(a + 1, k - 1) > reach(a, k - 1)) pick = a + 1;
      times[k] = times[pick];
      lanes[k] = lanes[pick];
    end
    count = kept;
    if (expo < MAX_EXP) expo++;
    arrivals = 0;
  endtask

  task automatic predict(logic fn, logic [111:0] d);
    result_t r;
    logic [31:0] mask;
    int unsigned idx;
    bit taken;
    r = '0;
    if (fn == FUNC_APPEND) begin
      mask = (32'd1 << expo) - 1;
      taken = (arrivals & mask) == 0;
      arrivals++;
      if (taken && count < DEPTH) begin
        times[count] = d[31:0];
        lanes[count] = d[95:32];
        count++;
        r.stored = 1'b1;
        if (count >= limit) halve();
      end
    end else begin
      idx = d[105:96];
      if (idx < count) begin
        r.rv = 1'b1;
        r.t = times[idx];
        {r.l3, r.l2, r.l1, r.l0} = lanes[idx];
      end
    end
    r.cnt = count;
    r.exp = expo;
    expected_q.insert(expected_q.size(), r);
  endtask

  always @(posedge clk) begin
    result_t e, a;
    int unsigned v;
    if (rst) begin
      count = 0; arrivals = 0; expo = 0; limit = DEPTH;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        v = cfg_data[10:0];
        limit = v < MIN_LIMIT ? MIN_LIMIT : (v > DEPTH ? DEPTH : v);
        count = 0; arrivals = 0; expo = 0;
      end
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        a = result_t'(m_tdata[113:0]);
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, a);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != a) begin
            $display("%0t: mismatch expected stored=%0d cnt=%0d exp=%0d rv=%0d t=%h lanes=%h",
                     $time, e.stored, e.cnt, e.exp, e.rv, e.t, {e.l3, e.l2, e.l1, e.l0});
            $display("%0t:          actual stored=%0d cnt=%0d exp=%0d rv=%0d t=%h lanes=%h",
                     $time, a.stored, a.cnt, a.exp, a.rv, a.t, {a.l3, a.l2, a.l1, a.l0});
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* dv/tb_adaptive_decimation_capture_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_decimation_capture_buffer
// Drives appends and reads through several sample limits with random idle
// gaps on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_adaptive_decimation_capture_buffer;
  import adcb_pkg::*;

  localparam int WATCHDOG = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic [111:0] s_tdata = '0;   // sample_time, lane0..lane3, read_index, zero pad
  logic         s_tuser = 1'b0; // func
  logic         m_tready = 1'b0;
  logic         cfg_ready, s_tready, m_tvalid;
  logic [119:0] m_tdata;        // was_stored, entry_count, exp, read_valid, time, lanes
  int           errors, pending, idle_cycles;
  bit           calm;           // while set, neither side idles

  always #6 clk = ~clk;

  adaptive_decimation_capture_buffer dut (.*);
  adcb_checker chk (.*);

  // The receiver stalls about 31 percent of the time unless the run is calm.
  always @(posedge clk) m_tready <= calm || $urandom_range(99) >= 31;

  // Watchdog: counts cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[adaptive_decimation_capture_buffer] ERROR");
      $finish;
    end
  end

  // Valid stays up from one item to the next unless an idle gap is drawn.
  task automatic send(logic fn, logic [31:0] t, logic [63:0] v, logic [9:0] idx);
    while (!calm && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {6'd0, idx, v, t};
    do @(posedge clk); while (!s_tready);
  endtask

  // Limit writes only happen when the block is quiet; a compaction pass ends
  // before its append's result, so the wait for every result also covers it.
  task automatic set_limit(logic [15:0] v);
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * DEPTH + 50) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random lanes: mostly full range, sometimes all lanes one small value (0 to 3)
  // so that ties and small reaches occur during compaction.
  function automatic logic [63:0] rand_lanes();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(3) == 0) v = {4{16'($urandom_range(3))}};
    return v;
  endfunction

  task automatic random_phase(int n, int cap);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2 && i < n / 2 + 80);
      if ($urandom_range(99) < 75) send(FUNC_APPEND, $urandom, rand_lanes(), 10'($urandom));
      else send(FUNC_READ, $urandom, {$urandom, $urandom}, 10'($urandom_range(cap)));
    end
    calm = 1'b0;
  endtask

  initial begin
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, reads beyond the count, then fill to a compaction.
    send(FUNC_READ, '1, '1, 10'd0);
    send(FUNC_APPEND, 32'hFFFF_FFFF, {4{16'h7FFF}}, 10'h3FF);
    send(FUNC_APPEND, 32'h0, {4{16'h8000}}, 10'h0);
    send(FUNC_APPEND, 32'h0, 64'h0, 10'h0);
    send(FUNC_READ, 32'h0, 64'h0, 10'd0);
    send(FUNC_READ, 32'h0, 64'h0, 10'd1);
    send(FUNC_READ, 32'h0, 64'h0, 10'd3);
    send(FUNC_READ, 32'h0, 64'h0, 10'h3FF);
    set_limit(16'd0);  // below the floor, acts as sixteen
    for (int i = 0; i < 18; i++) send(FUNC_APPEND, i, {4{16'(i * 3)}}, 10'd0);
    random_phase(300, 20);
    set_limit(16'hFFFF); // above the top, acts as the full depth
    random_phase(300, 1023);
    set_limit(16'd17);
    random_phase(350, 20);
    set_limit(16'd40);
    random_phase(350, 45);
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("[adaptive_decimation_capture_buffer] OK");
    else
      $display("[adaptive_decimation_capture_buffer] ERROR");
    $finish;
  end
endmodule
